### rtl/umx_pkg.sv
// umx_pkg: shared types, opcodes, status codes and sizes of the universal machine execute unit
// no dependencies; used by every module under rtl
package umx_pkg;

  localparam int NUM_REGS = 8;
  localparam int WORD_W   = 32;

  // opcode and register field positions in the instruction word
  localparam int OP_LSB     = 28;
  localparam int LI_REG_LSB = 25;
  localparam int LI_VAL_W   = 25;
  localparam int A_LSB      = 6;
  localparam int B_LSB      = 3;
  localparam int C_LSB      = 0;

  localparam logic [3:0] OP_CMOV   = 4'd0;
  localparam logic [3:0] OP_SLOAD  = 4'd1;
  localparam logic [3:0] OP_SSTORE = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_MUL    = 4'd4;
  localparam logic [3:0] OP_DIV    = 4'd5;
  localparam logic [3:0] OP_NAND   = 4'd6;
  localparam logic [3:0] OP_HALT   = 4'd7;
  localparam logic [3:0] OP_MAP    = 4'd8;
  localparam logic [3:0] OP_UNMAP  = 4'd9;
  localparam logic [3:0] OP_OUT    = 4'd10;
  localparam logic [3:0] OP_IN     = 4'd11;
  localparam logic [3:0] OP_LOADP  = 4'd12;
  localparam logic [3:0] OP_LI     = 4'd13;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALTED  = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_MEMOP   = 3'd3;
  localparam logic [2:0] ST_ILLEGAL = 3'd4;

  typedef struct packed {
    logic [31:0] insn;
    logic [7:0]  in_byte;
    logic        in_eof;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_char;
    logic        out_valid;
    logic [31:0] next_pc;
    logic        program_load;
    logic [31:0] load_segment;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

endpackage

### rtl/umx_regfile.sv
// umx_regfile: general register file, one write port and two registered read ports
// uses umx_pkg for the word width; valid bits make unwritten registers read as zero
module umx_regfile #(
  parameter int NUM_REGS = umx_pkg::NUM_REGS,
  parameter int AW       = $clog2(NUM_REGS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [umx_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr_b,
  input  logic [AW-1:0]              raddr_c,
  output logic [umx_pkg::WORD_W-1:0] rdata_b,
  output logic [umx_pkg::WORD_W-1:0] rdata_c
);

  logic [umx_pkg::WORD_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]        valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_b <= valid[raddr_b] ? mem[raddr_b] : '0;
      rdata_c <= valid[raddr_c] ? mem[raddr_c] : '0;
    end
  end

endmodule

### rtl/umx_divider.sv
// umx_divider: restoring unsigned divider, one quotient bit per cycle
// uses umx_pkg for the default width; divisor must be nonzero when started
module umx_divider #(
  parameter int W = umx_pkg::WORD_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  den;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    shifted = {rem, quo[W-1]};
    diff    = shifted - {1'b0, den};
    ge      = ~diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

### rtl/universal_machine_execute_unit.sv
// universal_machine_execute_unit: executes one fetched instruction per input transaction
// steps: register read, execute (result registered), commit to the output register and pc;
// commit waits while the output holds an untaken result; a nonzero divide first waits for the
// bit-serial divider (one quotient bit a cycle); a new transaction is taken only after commit
// reset (rst, synchronous): registers read as zero, pc zero, not halted, no result pending
// uses umx_pkg, umx_regfile and umx_divider
module universal_machine_execute_unit #(
  parameter int NUM_REGS = umx_pkg::NUM_REGS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  umx_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output umx_pkg::out_t  out_data
);

  localparam int AW = $clog2(NUM_REGS);
  localparam int W  = umx_pkg::WORD_W;

  umx_pkg::state_t state, state_next;

  umx_pkg::in_t  item;
  umx_pkg::out_t res, res_next;
  logic          wen, wen_next;
  logic [AW-1:0] waddr, waddr_next;
  logic [W-1:0]  wdata, wdata_next;
  logic          halt_set, halt_set_next;
  logic [W-1:0]  pc;
  logic          halted;

  logic          accept;
  logic          load_out;
  logic          rf_we;
  logic [W-1:0]  rb, rc;
  logic [W-1:0]  mul;
  logic          div_start;
  logic          div_done;
  logic [W-1:0]  quotient;
  logic [3:0]    op;
  logic [AW-1:0] ia, ib, ic, ili;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == umx_pkg::S_IDLE);
  assign load_out = (state == umx_pkg::S_DONE) && (!out_valid || out_ready);
  assign rf_we    = load_out && wen;

  assign op  = item.insn[umx_pkg::OP_LSB +: 4];
  assign ia  = item.insn[umx_pkg::A_LSB +: AW];
  assign ib  = item.insn[umx_pkg::B_LSB +: AW];
  assign ic  = item.insn[umx_pkg::C_LSB +: AW];
  assign ili = item.insn[umx_pkg::LI_REG_LSB +: AW];
  assign mul = rb * rc;

  umx_regfile #(
    .NUM_REGS (NUM_REGS),
    .AW       (AW)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (rf_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (accept),
    .raddr_b (in_data.insn[umx_pkg::B_LSB +: AW]),
    .raddr_c (in_data.insn[umx_pkg::C_LSB +: AW]),
    .rdata_b (rb),
    .rdata_c (rc)
  );

  umx_divider #(
    .W (W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rb),
    .divisor  (rc),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= umx_pkg::S_IDLE;
      out_valid <= 1'b0;
      pc        <= '0;
      halted    <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
        pc        <= res.next_pc;
        if (halt_set) begin
          halted <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (load_out) begin
      out_data <= res;
    end
    res      <= res_next;
    wen      <= wen_next;
    waddr    <= waddr_next;
    wdata    <= wdata_next;
    halt_set <= halt_set_next;
  end

  always_comb begin
    state_next    = state;
    res_next      = res;
    wen_next      = wen;
    waddr_next    = waddr;
    wdata_next    = wdata;
    halt_set_next = halt_set;
    div_start     = 1'b0;
    case (state)
      umx_pkg::S_IDLE: begin
        if (accept) begin
          state_next = umx_pkg::S_EXEC;
        end
      end
      umx_pkg::S_EXEC: begin
        res_next         = '0;
        res_next.status  = umx_pkg::ST_OK;
        res_next.next_pc = pc + 1'b1;
        wen_next         = 1'b0;
        waddr_next       = ia;
        wdata_next       = '0;
        halt_set_next    = 1'b0;
        state_next       = umx_pkg::S_DONE;
        if (halted) begin
          res_next.status  = umx_pkg::ST_HALTED;
          res_next.next_pc = pc;
        end else begin
          case (op)
            umx_pkg::OP_CMOV: begin
              wen_next   = (rc != '0);
              wdata_next = rb;
            end
            umx_pkg::OP_ADD: begin
              wen_next   = 1'b1;
              wdata_next = rb + rc;
            end
            umx_pkg::OP_MUL: begin
              wen_next   = 1'b1;
              wdata_next = mul;
            end
            umx_pkg::OP_DIV: begin
              if (rc == '0) begin
                res_next.status = umx_pkg::ST_DIVZERO;
              end else begin
                wen_next   = 1'b1;
                div_start  = 1'b1;
                state_next = umx_pkg::S_DIV;
              end
            end
            umx_pkg::OP_NAND: begin
              wen_next   = 1'b1;
              wdata_next = ~(rb & rc);
            end
            umx_pkg::OP_HALT: begin
              halt_set_next    = 1'b1;
              res_next.status  = umx_pkg::ST_HALTED;
              res_next.next_pc = pc;
            end
            umx_pkg::OP_OUT: begin
              res_next.out_char  = rc[7:0];
              res_next.out_valid = 1'b1;
            end
            umx_pkg::OP_IN: begin
              wen_next   = 1'b1;
              waddr_next = ic;
              wdata_next = item.in_eof ? '1 : W'(item.in_byte);
            end
            umx_pkg::OP_LOADP: begin
              res_next.next_pc = rc;
              if (rb != '0) begin
                res_next.program_load = 1'b1;
                res_next.load_segment = rb;
              end
            end
            umx_pkg::OP_LI: begin
              wen_next   = 1'b1;
              waddr_next = ili;
              wdata_next = W'(item.insn[umx_pkg::LI_VAL_W-1:0]);
            end
            umx_pkg::OP_SLOAD, umx_pkg::OP_SSTORE, umx_pkg::OP_MAP, umx_pkg::OP_UNMAP: begin
              res_next.status = umx_pkg::ST_MEMOP;
            end
            default: begin
              res_next.status = umx_pkg::ST_ILLEGAL;
            end
          endcase
        end
      end
      umx_pkg::S_DIV: begin
        if (div_done) begin
          wdata_next = quotient;
          state_next = umx_pkg::S_DONE;
        end
      end
      umx_pkg::S_DONE: begin
        if (load_out) begin
          state_next = umx_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = umx_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a halted machine never writes a register
  a_halted_no_write: assert property (@(posedge clk) disable iff (rst) halted |-> !rf_we)
    else $error("register write while halted");

  // the committed pc follows the result just loaded
  a_pc_commit: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (pc == out_data.next_pc))
    else $error("pc does not match emitted next_pc");

  // the divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == umx_pkg::S_DIV))
    else $error("divider finished outside divide wait");

  // a divide is only started with a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (rc != '0))
    else $error("divider started with zero divisor");
`endif

endmodule

### test/tb_universal_machine_execute_unit.sv
// tb_universal_machine_execute_unit: self-checking bench for the um-32 execute unit
// directed rows, random streams, then halt rows; results checked against the table or a predictor
// depends on umx_pkg and universal_machine_execute_unit under rtl
module tb_universal_machine_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] OP_ILL14 = 4'd14;
  localparam logic [3:0] OP_ILL15 = 4'd15;

  typedef struct {
    umx_pkg::in_t  txn;
    bit            typed;
    umx_pkg::out_t result;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  umx_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  umx_pkg::out_t out_data;

  // predictor state
  logic [31:0] gpr [umx_pkg::NUM_REGS];
  logic [31:0] arch_pc;
  bit          arch_halted;

  umx_pkg::out_t pending_results [$];
  stim_row_t     stim_table [$];
  int unsigned   err_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   ready_span = 0;
  int unsigned   ready_mode = 0;

  universal_machine_execute_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic umx_pkg::out_t execute_instr(input umx_pkg::in_t t);
    umx_pkg::out_t r;
    logic [3:0]    op;
    logic [2:0]    ra, rb, rc;
    logic [31:0]   npc;
    r   = '0;
    op  = t.insn[31:28];
    ra  = t.insn[8:6];
    rb  = t.insn[5:3];
    rc  = t.insn[2:0];
    npc = arch_pc + 32'd1;
    if (arch_halted) begin
      r.status = umx_pkg::ST_HALTED;
      npc = arch_pc;
    end else begin
      r.status = umx_pkg::ST_OK;
      case (op)
        umx_pkg::OP_CMOV: if (gpr[rc] != 0) gpr[ra] = gpr[rb];
        umx_pkg::OP_ADD:  gpr[ra] = gpr[rb] + gpr[rc];
        umx_pkg::OP_MUL:  gpr[ra] = gpr[rb] * gpr[rc];
        umx_pkg::OP_DIV: begin
          if (gpr[rc] == 0) r.status = umx_pkg::ST_DIVZERO;
          else gpr[ra] = gpr[rb] / gpr[rc];
        end
        umx_pkg::OP_NAND: gpr[ra] = ~(gpr[rb] & gpr[rc]);
        umx_pkg::OP_HALT: begin
          arch_halted = 1'b1;
          r.status = umx_pkg::ST_HALTED;
          npc = arch_pc;
        end
        umx_pkg::OP_OUT: begin
          r.out_char  = gpr[rc][7:0];
          r.out_valid = 1'b1;
        end
        umx_pkg::OP_IN: gpr[rc] = t.in_eof ? 32'hFFFF_FFFF : {24'd0, t.in_byte};
        umx_pkg::OP_LOADP: begin
          if (gpr[rb] != 0) begin
            r.program_load = 1'b1;
            r.load_segment = gpr[rb];
          end
          npc = gpr[rc];
        end
        umx_pkg::OP_LI: gpr[t.insn[27:25]] = {7'd0, t.insn[24:0]};
        umx_pkg::OP_SLOAD, umx_pkg::OP_SSTORE, umx_pkg::OP_MAP, umx_pkg::OP_UNMAP:
          r.status = umx_pkg::ST_MEMOP;
        default: r.status = umx_pkg::ST_ILLEGAL;
      endcase
      arch_pc = npc;
    end
    r.next_pc = npc;
    return r;
  endfunction

  function automatic umx_pkg::in_t mk_instr(input logic [3:0] op, input logic [2:0] ra, rb, rc,
                                            input logic [7:0] byt, input logic eof);
    umx_pkg::in_t t;
    t.insn          = $urandom;
    t.insn[31:28]   = op;
    t.insn[8:6]     = ra;
    t.insn[5:3]     = rb;
    t.insn[2:0]     = rc;
    t.in_byte       = byt;
    t.in_eof        = eof;
    return t;
  endfunction

  function automatic umx_pkg::in_t mk_li(input logic [2:0] ra, input logic [24:0] val);
    umx_pkg::in_t t;
    t.insn    = {umx_pkg::OP_LI, ra, val};
    t.in_byte = 8'($urandom);
    t.in_eof  = 1'b0;
    return t;
  endfunction

  function automatic umx_pkg::out_t mk_res(input logic [2:0] st, input logic [7:0] ch,
                                           input logic ov, input logic [31:0] npc,
                                           input logic pl, input logic [31:0] seg);
    umx_pkg::out_t r;
    r.status       = st;
    r.out_char     = ch;
    r.out_valid    = ov;
    r.next_pc      = npc;
    r.program_load = pl;
    r.load_segment = seg;
    return r;
  endfunction

  task automatic add_row(input umx_pkg::in_t t, input bit typed, input umx_pkg::out_t r);
    stim_row_t row;
    row.txn    = t;
    row.typed  = typed;
    row.result = r;
    stim_table.push_back(row);
  endtask

  // one transaction; the caller owns the drop of in_valid
  task automatic drive_txn(input umx_pkg::in_t t, input bit typed,
                           input umx_pkg::out_t typed_res);
    umx_pkg::out_t r;
    in_data  <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = execute_instr(t);
    if (typed) r = typed_res;
    pending_results.push_back(r);
  endtask

  task automatic issue(input umx_pkg::in_t t, input bit typed, input umx_pkg::out_t typed_res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    drive_txn(t, typed, typed_res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic bit field_bad(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // receiver: stall pattern (always ready, mostly ready, mostly stalled) changes after each random span
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_span = $urandom_range(16, 80);
      ready_mode = $urandom_range(0, 2);
    end
    ready_span--;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    umx_pkg::out_t exp_r;
    bit            bad;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual %p", $time, out_data);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        bad = 1'b0;
        bad |= field_bad("status", 32'(exp_r.status), 32'(out_data.status));
        bad |= field_bad("out_char", 32'(exp_r.out_char), 32'(out_data.out_char));
        bad |= field_bad("out_valid", 32'(exp_r.out_valid), 32'(out_data.out_valid));
        bad |= field_bad("next_pc", exp_r.next_pc, out_data.next_pc);
        bad |= field_bad("program_load", 32'(exp_r.program_load),
                         32'(out_data.program_load));
        bad |= field_bad("load_segment", exp_r.load_segment, out_data.load_segment);
        if (bad) err_count++;
      end
    end
  end

  initial begin
    int           halt_row;
    int           i;
    int unsigned  pick;
    logic [3:0]   op;
    umx_pkg::in_t t;

    for (i = 0; i < umx_pkg::NUM_REGS; i++) gpr[i] = '0;
    arch_pc     = '0;
    arch_halted = 1'b0;

    // pc runs 0,1,2,... until the two jumps near the end
    add_row(mk_li(3'd0, 25'h1FF_FFFF), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b0, 32'd1, 1'b0, 32'd0));
    add_row(mk_li(3'd1, 25'h0), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b0, 32'd2, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_NAND, 3'd2, 3'd1, 3'd1, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b0, 32'd3, 1'b0, 32'd0));
    // output of a register above 255 gives its low byte
    add_row(mk_instr(umx_pkg::OP_OUT, 3'd0, 3'd0, 3'd2, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'hFF, 1'b1, 32'd4, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_DIV, 3'd3, 3'd2, 3'd1, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_DIVZERO, 8'h00, 1'b0, 32'd5, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_ADD, 3'd3, 3'd2, 3'd2, 8'h00, 1'b0), 1'b0, '0);
    add_row(mk_instr(umx_pkg::OP_MUL, 3'd4, 3'd2, 3'd0, 8'h00, 1'b0), 1'b0, '0);
    add_row(mk_instr(umx_pkg::OP_DIV, 3'd5, 3'd2, 3'd0, 8'h00, 1'b0), 1'b0, '0);
    add_row(mk_instr(umx_pkg::OP_CMOV, 3'd6, 3'd0, 3'd1, 8'h00, 1'b0), 1'b0, '0);
    add_row(mk_instr(umx_pkg::OP_CMOV, 3'd6, 3'd0, 3'd2, 8'h00, 1'b0), 1'b0, '0);
    add_row(mk_instr(umx_pkg::OP_IN, 3'd0, 3'd0, 3'd7, 8'hA5, 1'b1), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b0, 32'd11, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_IN, 3'd0, 3'd0, 3'd7, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b0, 32'd12, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_OUT, 3'd0, 3'd0, 3'd7, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b1, 32'd13, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_IN, 3'd0, 3'd0, 3'd7, 8'hFF, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b0, 32'd14, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_SLOAD, 3'd1, 3'd2, 3'd3, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_MEMOP, 8'h00, 1'b0, 32'd15, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_SSTORE, 3'd1, 3'd2, 3'd3, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_MEMOP, 8'h00, 1'b0, 32'd16, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_MAP, 3'd1, 3'd2, 3'd3, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_MEMOP, 8'h00, 1'b0, 32'd17, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_UNMAP, 3'd1, 3'd2, 3'd3, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_MEMOP, 8'h00, 1'b0, 32'd18, 1'b0, 32'd0));
    add_row(mk_instr(OP_ILL14, 3'd1, 3'd2, 3'd3, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_ILLEGAL, 8'h00, 1'b0, 32'd19, 1'b0, 32'd0));
    add_row(mk_instr(OP_ILL15, 3'd1, 3'd2, 3'd3, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_ILLEGAL, 8'h00, 1'b0, 32'd20, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_OUT, 3'd0, 3'd0, 3'd7, 8'h00, 1'b0), 1'b0, '0);
    // load-program from a zero segment register: jump only
    add_row(mk_instr(umx_pkg::OP_LOADP, 3'd0, 3'd1, 3'd0, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b0, 32'h01FF_FFFF, 1'b0, 32'd0));
    add_row(mk_instr(umx_pkg::OP_LOADP, 3'd0, 3'd2, 3'd1, 8'h00, 1'b0), 1'b1,
            mk_res(umx_pkg::ST_OK, 8'h00, 1'b0, 32'd0, 1'b1, 32'hFFFF_FFFF));
    add_row(mk_instr(umx_pkg::OP_ADD, 3'd7, 3'd7, 3'd7, 8'h00, 1'b0), 1'b0, '0);
    halt_row = stim_table.size();
    // halt comes after the random streams, then rows that see it held: only reset clears it
    add_row(mk_instr(umx_pkg::OP_HALT, 3'd7, 3'd7, 3'd7, 8'hFF, 1'b1), 1'b0, '0);
    add_row(mk_li(3'd7, 25'h155_5555), 1'b0, '0);
    add_row(mk_instr(umx_pkg::OP_OUT, 3'd0, 3'd0, 3'd2, 8'h00, 1'b0), 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < halt_row; i++)
      issue(stim_table[i].txn, stim_table[i].typed, stim_table[i].result);
    drain_results();

    for (i = 0; i < 850; i++) begin
      if (i == 425) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 25) op = umx_pkg::OP_LI;
      else begin
        op = 4'($urandom_range(0, 15));
        if (op == umx_pkg::OP_HALT) op = umx_pkg::OP_NAND;
      end
      t.insn        = $urandom;
      t.insn[31:28] = op;
      t.in_byte     = 8'($urandom);
      t.in_eof      = ($urandom_range(0, 7) == 0);
      issue(t, 1'b0, '0);
    end

    for (i = halt_row; i < stim_table.size(); i++)
      issue(stim_table[i].txn, stim_table[i].typed, stim_table[i].result);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
rtl/umx_pkg.sv
rtl/umx_regfile.sv
rtl/umx_divider.sv
rtl/universal_machine_execute_unit.sv
test/tb_universal_machine_execute_unit.sv
